>>> rtl/load_cell_weight_filter_unit_defines.svh
// Assertion macros of the load cell weight filter checker.
`ifndef LOAD_CELL_WEIGHT_FILTER_UNIT_DEFINES_SVH
`define LOAD_CELL_WEIGHT_FILTER_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define LCWF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define LCWF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lcwf_pkg.sv
// Shared types and constants of the load cell weight filter.
`default_nettype none

package lcwf_pkg;

   // Fixed field widths.
   localparam int W_BITS         = 40;
   localparam int FRAC_BITS      = 16;
   localparam int ALPHA_BITS     = 17;
   localparam int GAIN_BITS      = 32;
   localparam int GAIN_SHIFT     = 8;
   localparam int BAND_BITS      = 39;
   localparam int SPR_BITS       = 5;
   localparam int CSR_DATA_BITS  = 39;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes of the control port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLES  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SNAP     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND = 3'd6;

   // Register reset values.
   localparam logic [SPR_BITS-1:0]   SPR_RESET   = 5'd1;
   localparam logic [ALPHA_BITS-1:0] ONE_Q16     = 17'h10000;

   // Saturation limits of a Q16 weight.
   localparam logic signed [W_BITS-1:0] W_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [W_BITS-1:0] W_MIN = 40'sh80_0000_0000;
   localparam logic [W_BITS-1:0] W_MAG_POS = 40'h7F_FFFF_FFFF;
   localparam logic [W_BITS-1:0] W_MAG_NEG = 40'h80_0000_0000;

   // Rounding addend for a ceiling shift by GAIN_SHIFT.
   localparam logic [GAIN_SHIFT-1:0] GAIN_ROUND = 8'hFF;

   // Smallest positive uncalibrated average that saturates when scaled to Q16.
   localparam int UNCAL_HI = 8388608;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic accept;
      logic div_step;
      logic avg_load;
      logic diff_load;
      logic mul_load;
      logic grams_load;
      logic ema_prep;
      logic ema_mul;
      logic ema_add;
      logic snap_load;
      logic decide;
      logic out_load;
   } lcwf_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic tare;
      logic reading_done;
      logic emit;
   } lcwf_status_type;

endpackage

`default_nettype wire

>>> rtl/lcwf_req_if.sv
// Input channel: raw samples and tare commands.
`default_nettype none

interface lcwf_req_if #(parameter int RAW_BITS = 24) ();
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic signed [RAW_BITS-1:0] raw_sample;

   modport source (output valid, output operation, output raw_sample, input ready);
   modport sink   (input valid, input operation, input raw_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/lcwf_rsp_if.sv
// Result channel: shown weights.
`default_nettype none

interface lcwf_rsp_if import lcwf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [W_BITS-1:0] weight;
   logic                     calibrated_flag;

   modport source (output valid, output weight, output calibrated_flag, input ready);
   modport sink   (input valid, input weight, input calibrated_flag, output ready);
endinterface

`default_nettype wire

>>> rtl/lcwf_ctrl.sv
// Sequencer of the load cell weight filter: steps one word through the datapath.
`default_nettype none

module lcwf_ctrl import lcwf_pkg::*; #(
   parameter int DIV_STEPS = 29
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire lcwf_status_type status,
   output lcwf_cmd_type         cmd
);

   localparam int STEP_BITS = $clog2(DIV_STEPS);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DIV      = 4'd1;
   localparam logic [3:0] ST_AVG      = 4'd2;
   localparam logic [3:0] ST_DIFF     = 4'd3;
   localparam logic [3:0] ST_MUL      = 4'd4;
   localparam logic [3:0] ST_GRAMS    = 4'd5;
   localparam logic [3:0] ST_EMA_PREP = 4'd6;
   localparam logic [3:0] ST_EMA_MUL  = 4'd7;
   localparam logic [3:0] ST_EMA_ADD  = 4'd8;
   localparam logic [3:0] ST_SNAP     = 4'd9;
   localparam logic [3:0] ST_DECIDE   = 4'd10;
   localparam logic [3:0] ST_EMIT     = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.tare) begin
                  state_in = ST_EMIT;
               end else if (status.reading_done) begin
                  state_in = ST_DIV;
                  step_in  = STEP_BITS'(DIV_STEPS - 1);
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_AVG;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_AVG: begin
            cmd.avg_load = 1'b1;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_GRAMS;
         end
         ST_GRAMS: begin
            cmd.grams_load = 1'b1;
            state_in       = ST_EMA_PREP;
         end
         ST_EMA_PREP: begin
            cmd.ema_prep = 1'b1;
            state_in     = ST_EMA_MUL;
         end
         ST_EMA_MUL: begin
            cmd.ema_mul = 1'b1;
            state_in    = ST_EMA_ADD;
         end
         ST_EMA_ADD: begin
            cmd.ema_add = 1'b1;
            state_in    = ST_SNAP;
         end
         ST_SNAP: begin
            cmd.snap_load = 1'b1;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.emit ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output word stays valid until it is taken.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lcwf_datapath.sv
// Datapath of the load cell weight filter: registers, divider, scaler and smoother.
`default_nettype none

module lcwf_datapath import lcwf_pkg::*; #(
   parameter int RAW_BITS    = 24,
   parameter int MAX_AVERAGE = 20
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lcwf_cmd_type               cmd,
   output lcwf_status_type                 status,
   input  wire logic                       req_operation,
   input  wire logic signed [RAW_BITS-1:0] req_raw_sample,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_wdata,
   output logic signed [W_BITS-1:0]        rsp_weight,
   output logic                            rsp_calibrated_flag
);

   localparam int SUM_BITS   = RAW_BITS + $clog2(MAX_AVERAGE);
   localparam int TALLY_BITS = $clog2(MAX_AVERAGE + 1);
   localparam int CNT_BITS   = (TALLY_BITS > SPR_BITS) ? TALLY_BITS : SPR_BITS;
   localparam int PROD_BITS  = RAW_BITS + GAIN_BITS;
   localparam int GW         = (PROD_BITS > W_BITS) ? PROD_BITS + 1 : W_BITS + 1;
   localparam int AW         = (RAW_BITS > 25) ? RAW_BITS + 1 : 26;
   localparam int D_BITS     = W_BITS + 1;
   localparam int MP_BITS    = ALPHA_BITS + 1 + D_BITS;

   localparam logic [CNT_BITS-1:0]  MAX_N   = CNT_BITS'(MAX_AVERAGE);
   localparam logic [CNT_BITS-1:0]  ONE_N   = CNT_BITS'(1);
   localparam logic [GW-1:0]        LIM_POS = GW'(W_MAG_POS);
   localparam logic [GW-1:0]        LIM_NEG = GW'(W_MAG_NEG);
   localparam logic [GW-1:0]        RND_ADD = GW'(GAIN_ROUND);
   localparam logic signed [AW-1:0] UNC_HI  = AW'(UNCAL_HI);
   localparam logic signed [AW-1:0] UNC_LO  = -UNC_HI;

   // Control registers.
   logic [SPR_BITS-1:0]        spr_ff, spr_in;
   logic signed [RAW_BITS-1:0] zero_ff, zero_in;
   logic [GAIN_BITS-1:0]       gain_ff, gain_in;
   logic                       cal_ff, cal_in;
   logic [ALPHA_BITS-1:0]      alpha_ff, alpha_in;
   logic [BAND_BITS-1:0]       snap_ff, snap_in;
   logic [BAND_BITS-1:0]       dead_ff, dead_in;
   logic                       csr_hit;

   // Filter state.
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [TALLY_BITS-1:0]      tally_ff, tally_in;
   logic signed [W_BITS-1:0]   smooth_ff, smooth_in;
   logic                       started_ff, started_in;
   logic signed [W_BITS-1:0]   last_ff, last_in;

   // Work registers of one reading.
   logic [SUM_BITS-1:0]        quo_ff, quo_in;
   logic [TALLY_BITS-1:0]      rem_ff, rem_in;
   logic [TALLY_BITS-1:0]      divisor_ff, divisor_in;
   logic                       neg_ff, neg_in;
   logic signed [RAW_BITS-1:0] avg_ff, avg_in;
   logic [RAW_BITS-1:0]        mag_ff, mag_in;
   logic                       dneg_ff, dneg_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic signed [W_BITS-1:0]   w_ff, w_in;
   logic signed [D_BITS-1:0]   ediff_ff, ediff_in;
   logic signed [W_BITS-1:0]   base_ff, base_in;
   logic signed [MP_BITS-1:0]  mprod_ff, mprod_in;
   logic signed [W_BITS-1:0]   shown_ff, shown_in;
   logic signed [W_BITS-1:0]   res_ff, res_in;
   logic signed [W_BITS-1:0]   rsp_weight_ff, rsp_weight_in;
   logic                       rsp_flag_ff, rsp_flag_in;

   // Intermediate values.
   logic signed [SUM_BITS-1:0] sample_x, sum_new;
   logic [CNT_BITS-1:0]        spr_x, n_eff, tally_next;
   logic [TALLY_BITS:0]        trial, trial_sub;
   logic                       fits;
   logic [SUM_BITS-1:0]        quo_neg;
   logic signed [RAW_BITS:0]   dfull, dabs;
   logic [GW-1:0]              prod_x, qpos, qneg;
   logic signed [W_BITS-1:0]   cal_w, uncal_w;
   logic signed [AW-1:0]       avg_x;
   logic [ALPHA_BITS-1:0]      a_cl;
   logic signed [ALPHA_BITS:0] a_s;
   logic signed [MP_BITS-1:0]  step_sh, snew;
   logic signed [D_BITS-1:0]   band_x, smooth_x, dd, dmag;
   logic                       in_band;

   // Register writes from the control port.
   always_comb begin
      spr_in   = spr_ff;
      zero_in  = zero_ff;
      gain_in  = gain_ff;
      cal_in   = cal_ff;
      alpha_in = alpha_ff;
      snap_in  = snap_ff;
      dead_in  = dead_ff;
      csr_hit  = 1'b0;
      if (csr_write_en) begin
         csr_hit = 1'b1;
         case (csr_index)
            CSR_SAMPLES:  spr_in   = csr_wdata[SPR_BITS-1:0];
            CSR_ZERO:     zero_in  = csr_wdata[RAW_BITS-1:0];
            CSR_GAIN:     gain_in  = csr_wdata[GAIN_BITS-1:0];
            CSR_CAL:      cal_in   = csr_wdata[0];
            CSR_ALPHA:    alpha_in = csr_wdata[ALPHA_BITS-1:0];
            CSR_SNAP:     snap_in  = csr_wdata[BAND_BITS-1:0];
            CSR_DEADBAND: dead_in  = csr_wdata[BAND_BITS-1:0];
            default:      csr_hit  = 1'b0;
         endcase
      end
   end

   // Sample accumulation and the effective block length.
   always_comb begin
      sample_x   = SUM_BITS'(req_raw_sample);
      sum_new    = sum_ff + sample_x;
      spr_x      = CNT_BITS'(spr_ff);
      if (spr_ff == '0) begin
         n_eff = ONE_N;
      end else if (spr_x > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = spr_x;
      end
      tally_next = CNT_BITS'(tally_ff) + ONE_N;
   end

   assign status.tare         = req_operation;
   assign status.reading_done = (tally_next >= n_eff);

   // One restoring division step on the magnitude of the sum.
   always_comb begin
      trial     = {rem_ff, quo_ff[SUM_BITS-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      fits      = (trial >= {1'b0, divisor_ff});
   end

   // Average, offset removal and Q16 scaling.
   always_comb begin
      quo_neg = -quo_ff;
      dfull   = (RAW_BITS+1)'(avg_ff) - (RAW_BITS+1)'(zero_ff);
      dabs    = dfull[RAW_BITS] ? -dfull : dfull;

      // Calibrated: floor for positive values, ceiling of the magnitude for negative ones.
      prod_x = GW'(prod_ff);
      qpos   = prod_x >> GAIN_SHIFT;
      qneg   = (prod_x + RND_ADD) >> GAIN_SHIFT;
      if (!dneg_ff) begin
         cal_w = (qpos > LIM_POS) ? W_MAX : qpos[W_BITS-1:0];
      end else begin
         cal_w = (qneg > LIM_NEG) ? W_MIN : -qneg[W_BITS-1:0];
      end

      // Uncalibrated: the average itself in Q16.
      avg_x = AW'(avg_ff);
      if (avg_x >= UNC_HI) begin
         uncal_w = W_MAX;
      end else if (avg_x < UNC_LO) begin
         uncal_w = W_MIN;
      end else begin
         uncal_w = {avg_x[W_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      end
   end

   // Smoothing, zero snap and deadband test.
   always_comb begin
      a_cl     = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
      a_s      = signed'({1'b0, a_cl});
      step_sh  = mprod_ff >>> FRAC_BITS;
      snew     = MP_BITS'(base_ff) + step_sh;
      band_x   = signed'({2'b00, snap_ff});
      smooth_x = D_BITS'(smooth_ff);
      in_band  = (smooth_x > -band_x) && (smooth_x < band_x);
      dd       = D_BITS'(shown_ff) - D_BITS'(last_ff);
      dmag     = dd[D_BITS-1] ? -dd : dd;
   end

   assign status.emit = !cal_ff || (unsigned'(dmag) >= {2'b00, dead_ff});

   // Next values of the state and work registers.
   always_comb begin
      sum_in        = sum_ff;
      tally_in      = tally_ff;
      smooth_in     = smooth_ff;
      started_in    = started_ff;
      last_in       = last_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      neg_in        = neg_ff;
      avg_in        = avg_ff;
      mag_in        = mag_ff;
      dneg_in       = dneg_ff;
      prod_in       = prod_ff;
      w_in          = w_ff;
      ediff_in      = ediff_ff;
      base_in       = base_ff;
      mprod_in      = mprod_ff;
      shown_in      = shown_ff;
      res_in        = res_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_flag_in   = rsp_flag_ff;

      // A tare word clears the smoother and queues a zero weight.
      if (cmd.accept && req_operation) begin
         smooth_in  = '0;
         last_in    = '0;
         started_in = 1'b0;
         res_in     = '0;
      end

      // A sample word either accumulates or closes a block and starts the divider.
      if (cmd.accept && !req_operation) begin
         if (status.reading_done) begin
            sum_in     = '0;
            tally_in   = '0;
            neg_in     = sum_new[SUM_BITS-1];
            quo_in     = sum_new[SUM_BITS-1] ? unsigned'(-sum_new) : unsigned'(sum_new);
            rem_in     = '0;
            divisor_in = tally_next[TALLY_BITS-1:0];
         end else begin
            sum_in   = sum_new;
            tally_in = tally_next[TALLY_BITS-1:0];
         end
      end

      if (cmd.div_step) begin
         rem_in = fits ? trial_sub[TALLY_BITS-1:0] : trial[TALLY_BITS-1:0];
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
      end

      if (cmd.avg_load) begin
         avg_in = neg_ff ? quo_neg[RAW_BITS-1:0] : quo_ff[RAW_BITS-1:0];
      end

      if (cmd.diff_load) begin
         mag_in  = dabs[RAW_BITS-1:0];
         dneg_in = dfull[RAW_BITS];
      end

      if (cmd.mul_load) begin
         prod_in = PROD_BITS'(mag_ff) * PROD_BITS'(gain_ff);
      end

      if (cmd.grams_load) begin
         w_in = cal_ff ? cal_w : uncal_w;
      end

      // The first reading after a restart seeds the smoother.
      if (cmd.ema_prep) begin
         ediff_in = started_ff ? (D_BITS'(w_ff) - D_BITS'(smooth_ff)) : '0;
         base_in  = started_ff ? smooth_ff : w_ff;
      end

      if (cmd.ema_mul) begin
         mprod_in = MP_BITS'(a_s) * MP_BITS'(ediff_ff);
      end

      if (cmd.ema_add) begin
         smooth_in  = snew[W_BITS-1:0];
         started_in = 1'b1;
      end

      if (cmd.snap_load) begin
         shown_in = (cal_ff && in_band) ? '0 : smooth_ff;
      end

      if (cmd.decide && status.emit) begin
         last_in = shown_ff;
         res_in  = shown_ff;
      end

      if (cmd.out_load) begin
         rsp_weight_in = res_ff;
         rsp_flag_in   = cal_ff;
      end

      // Any register write restarts the smoother.
      if (csr_hit) begin
         started_in = 1'b0;
      end
   end

   // Control registers and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff     <= SPR_RESET;
         zero_ff    <= '0;
         gain_ff    <= '0;
         cal_ff     <= 1'b0;
         alpha_ff   <= ONE_Q16;
         snap_ff    <= '0;
         dead_ff    <= '0;
         sum_ff     <= '0;
         tally_ff   <= '0;
         smooth_ff  <= '0;
         started_ff <= 1'b0;
         last_ff    <= '0;
      end else begin
         spr_ff     <= spr_in;
         zero_ff    <= zero_in;
         gain_ff    <= gain_in;
         cal_ff     <= cal_in;
         alpha_ff   <= alpha_in;
         snap_ff    <= snap_in;
         dead_ff    <= dead_in;
         sum_ff     <= sum_in;
         tally_ff   <= tally_in;
         smooth_ff  <= smooth_in;
         started_ff <= started_in;
         last_ff    <= last_in;
      end
   end

   // Work and output registers.
   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      neg_ff        <= neg_in;
      avg_ff        <= avg_in;
      mag_ff        <= mag_in;
      dneg_ff       <= dneg_in;
      prod_ff       <= prod_in;
      w_ff          <= w_in;
      ediff_ff      <= ediff_in;
      base_ff       <= base_in;
      mprod_ff      <= mprod_in;
      shown_ff      <= shown_in;
      res_ff        <= res_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_weight          = rsp_weight_ff;
   assign rsp_calibrated_flag = rsp_flag_ff;

endmodule

`default_nettype wire

>>> rtl/load_cell_weight_filter_unit.sv
// Load cell weight filter: averaging, scaling, smoothing and deadband of raw samples.
//
// The req_chan channel takes one word per item: a raw converter sample or a tare
// command. The rsp_chan channel gives the shown weight in Q16 grams with a copy
// of the calibration bit. Both channels move a word when valid and ready are high.
// The user must write registers through csr_write_en, csr_index and csr_wdata
// only while idle; the block itself does not enforce it. A sample that does not
// close a block is accumulated and the input stays ready. A sample that closes a
// block runs the serial divider, one quotient bit per cycle, over all
// RAW_BITS + clog2(MAX_AVERAGE) quotient bits, then averages, removes the offset,
// scales, smooths, snaps to zero and tests the deadband; the output register is
// loaded only if the test passes or calibration is off, and only after that is
// the next word taken. A tare word queues a zero weight. A result that the
// receiver does not take waits in the output register while the next word is
// accepted; a later result waits in the sequencer until the register is free.
// Synchronous reset restores the register defaults and clears the sum, the
// smoother and the last shown weight; no result is pending after reset.
`default_nettype none

module load_cell_weight_filter_unit import lcwf_pkg::*; #(
   parameter int MAX_AVERAGE = 20,
   parameter int RAW_BITS    = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   lcwf_req_if.sink                       req_chan,
   lcwf_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DIV_STEPS = RAW_BITS + $clog2(MAX_AVERAGE);

   lcwf_cmd_type             cmd;
   lcwf_status_type          status;
   logic                     req_ready;
   logic                     rsp_valid;
   logic signed [W_BITS-1:0] rsp_weight;
   logic                     rsp_calibrated_flag;

   // Sequencer.
   lcwf_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   lcwf_datapath #(
      .RAW_BITS    (RAW_BITS),
      .MAX_AVERAGE (MAX_AVERAGE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_chan.operation),
      .req_raw_sample      (req_chan.raw_sample),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_weight          (rsp_weight),
      .rsp_calibrated_flag (rsp_calibrated_flag)
   );

   // Channel outputs.
   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.weight          = rsp_weight;
   assign rsp_chan.calibrated_flag = rsp_calibrated_flag;

endmodule

`default_nettype wire

>>> rtl/lcwf_checker.sv
// Port checker of the load cell weight filter and its bind statement.
`default_nettype none

`include "load_cell_weight_filter_unit_defines.svh"

module lcwf_checker import lcwf_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_operation,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [W_BITS-1:0] rsp_weight,
   input wire logic                     rsp_flag
);

   // A stalled result word holds its value.
   `LCWF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight) && $stable(rsp_flag), "stalled result word changed")

   // A tare word blocks the input for the cycle in which its zero weight is queued.
   `LCWF_ASSERT(a_tare_busy, clock, reset, req_valid && req_ready && req_operation |=> !req_ready, "input ready right after a tare word")

   // A new result appears only right after the sequencer was busy.
   `LCWF_ASSERT(a_rsp_after_busy, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "result appeared without a busy cycle")

   // Reset leaves no result pending.
   `LCWF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind load_cell_weight_filter_unit lcwf_checker u_lcwf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_weight    (rsp_chan.weight),
   .rsp_flag      (rsp_chan.calibrated_flag)
);

`default_nettype wire
